// File: rtl/overwrite_oldest_frame_fifo_unit_macros.svh
// assertion macros used by the checker file
`ifndef OVERWRITE_OLDEST_FRAME_FIFO_UNIT_MACROS_SVH
`define OVERWRITE_OLDEST_FRAME_FIFO_UNIT_MACROS_SVH

// clocked assertion, off while reset is asserted, with a custom message
`define OOFF_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion with the standard message
`define OOFF_ASSERT(lbl, prop) \
  `OOFF_ASSERT_MSG(lbl, prop, "frame fifo check failed")

`endif

// File: rtl/ooff_pkg.sv
package ooff_pkg;

  // queue geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // field widths
  localparam int unsigned MODE_W = 2;
  localparam int unsigned ID_W   = 29;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned CTR_W  = 32;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  // one stored frame with its insertion time
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              ext;
    logic              rtr;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] payload;
    logic [TIME_W-1:0] stamp;
  } frame_t;

  // per-cell control
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // accepted operation as seen by the statistics block
  typedef struct packed {
    logic              fire;
    logic [MODE_W-1:0] mode;
  } step_t;

  // statistics state
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] peak;
    logic [CTR_W-1:0] put_total;
    logic [CTR_W-1:0] get_total;
    logic [CTR_W-1:0] ovf_total;
  } stats_t;

endpackage

// File: rtl/ooff_cell.sv
module ooff_cell (
  input  logic               clk_i,
  input  ooff_pkg::cell_ctrl_t ctrl_i,
  input  ooff_pkg::frame_t   new_i,
  input  ooff_pkg::frame_t   nbr_i,
  output ooff_pkg::frame_t   data_o
);

  ooff_pkg::frame_t data_q, data_d;

  // load a new frame or take the neighbor's frame on a shift
  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = new_i;
    end else if (ctrl_i.shift) begin
      data_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: rtl/ooff_stats.sv
module ooff_stats (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ooff_pkg::step_t   step_i,
  output ooff_pkg::stats_t  stats_o
);

  ooff_pkg::stats_t stats_q, stats_d;
  logic             full;
  logic             empty;

  assign full  = (stats_q.count == ooff_pkg::CNT_W'(ooff_pkg::DEPTH));
  assign empty = (stats_q.count == '0);

  // occupancy, high-water mark and wrapping counters
  always_comb begin
    stats_d = stats_q;
    if (step_i.fire) begin
      unique case (step_i.mode)
        ooff_pkg::MODE_PUT: begin
          stats_d.put_total = stats_q.put_total + 1'b1;
          if (full) begin
            stats_d.ovf_total = stats_q.ovf_total + 1'b1;
          end else begin
            stats_d.count = stats_q.count + 1'b1;
          end
          if (stats_d.count > stats_q.peak) begin
            stats_d.peak = stats_d.count;
          end
        end
        ooff_pkg::MODE_GET: begin
          if (!empty) begin
            stats_d.count     = stats_q.count - 1'b1;
            stats_d.get_total = stats_q.get_total + 1'b1;
          end
        end
        ooff_pkg::MODE_PEEK: begin
          stats_d = stats_q;
        end
        ooff_pkg::MODE_CLEAR: begin
          stats_d.count = '0;
        end
        default: begin
          stats_d = stats_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_q <= '0;
    end else begin
      stats_q <= stats_d;
    end
  end

  assign stats_o = stats_q;

endmodule

// File: rtl/overwrite_oldest_frame_fifo_unit.sv
// Overwrite-oldest queue of CAN frames with insertion timestamps.
// Input channel: in_valid_i / in_stall_o carry one operation per beat
// (mode_i: put, get, peek or clear) with the frame fields and now_us_i.
// Output channel: out_valid_o / out_stall_i carry exactly one result beat
// per input beat, in order: the returned frame (item_valid_o set when a
// get or peek found one, all frame fields zero otherwise) and the
// occupancy, high-water mark and put, get and overflow counters after it.
// Frames sit in a row of identical cells, oldest in cell zero. A get, or a
// put into a full queue, moves every frame one cell toward cell zero;
// other puts load the first free cell.
// The result is registered and appears in the cycle after the beat is taken.
// Throughput: one beat per cycle while out_stall_i holds no result, bounded
// by the single shift step of the cell row and the one result register.
// Reset empties the queue, clears all counters and the high-water mark and
// drops any pending result; no clearing pass is needed.
// While out_stall_i holds a pending result, in_stall_o is raised and no new
// beat is taken; the result and statistics stay stable.
module overwrite_oldest_frame_fifo_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ooff_pkg::MODE_W-1:0]   mode_i,
  input  logic [ooff_pkg::ID_W-1:0]     frame_id_i,
  input  logic                          frame_ext_i,
  input  logic                          frame_rtr_i,
  input  logic [ooff_pkg::LEN_W-1:0]    frame_len_i,
  input  logic [ooff_pkg::DATA_W-1:0]   frame_payload_i,
  input  logic [ooff_pkg::TIME_W-1:0]   now_us_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          item_valid_o,
  output logic [ooff_pkg::ID_W-1:0]     out_id_o,
  output logic                          out_ext_o,
  output logic                          out_rtr_o,
  output logic [ooff_pkg::LEN_W-1:0]    out_len_o,
  output logic [ooff_pkg::DATA_W-1:0]   out_payload_o,
  output logic [ooff_pkg::TIME_W-1:0]   out_time_o,
  output logic [ooff_pkg::OCC_W-1:0]    occupancy_o,
  output logic [ooff_pkg::OCC_W-1:0]    high_water_o,
  output logic [ooff_pkg::CTR_W-1:0]    put_total_o,
  output logic [ooff_pkg::CTR_W-1:0]    get_total_o,
  output logic [ooff_pkg::CTR_W-1:0]    overflow_total_o
);

  logic                 accept;
  logic                 out_valid_q;
  logic                 item_valid_q;
  ooff_pkg::frame_t     frame_q;
  ooff_pkg::frame_t     new_frame;
  ooff_pkg::frame_t     cell_data [ooff_pkg::DEPTH];
  ooff_pkg::cell_ctrl_t cell_ctrl [ooff_pkg::DEPTH];
  ooff_pkg::step_t      step;
  ooff_pkg::stats_t     stats;
  logic                 is_put;
  logic                 is_get;
  logic                 hit;
  logic                 full;
  logic                 empty;
  logic                 shift_all;

  // handshake: take a beat when the result slot is free or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign new_frame.id      = frame_id_i;
  assign new_frame.ext     = frame_ext_i;
  assign new_frame.rtr     = frame_rtr_i;
  assign new_frame.len     = frame_len_i;
  assign new_frame.payload = frame_payload_i;
  assign new_frame.stamp   = now_us_i;

  // statistics
  assign step.fire = accept;
  assign step.mode = mode_i;

  ooff_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .stats_o (stats)
  );

  // operation decode
  assign full      = (stats.count == ooff_pkg::CNT_W'(ooff_pkg::DEPTH));
  assign empty     = (stats.count == '0);
  assign is_put    = accept && (mode_i == ooff_pkg::MODE_PUT);
  assign is_get    = accept && (mode_i == ooff_pkg::MODE_GET);
  assign hit       = !empty && ((mode_i == ooff_pkg::MODE_GET) ||
                                (mode_i == ooff_pkg::MODE_PEEK));
  assign shift_all = (is_put && full) || (is_get && !empty);

  // cell row, oldest frame in cell zero
  for (genvar k = 0; k < ooff_pkg::DEPTH; k++) begin : g_cell
    ooff_pkg::frame_t nbr;

    if (k == ooff_pkg::DEPTH - 1) begin : g_last
      assign nbr = new_frame;
      assign cell_ctrl[k].load = is_put;
    end else begin : g_mid
      assign nbr = cell_data[k+1];
      assign cell_ctrl[k].load = is_put && !full &&
                                 (stats.count == ooff_pkg::CNT_W'(k));
    end
    assign cell_ctrl[k].shift = shift_all;

    ooff_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[k]),
      .new_i  (new_frame),
      .nbr_i  (nbr),
      .data_o (cell_data[k])
    );
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      item_valid_q <= 1'b0;
      frame_q      <= '0;
    end else begin
      if (accept) begin
        out_valid_q  <= 1'b1;
        item_valid_q <= hit;
        frame_q      <= hit ? cell_data[0] : '0;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign item_valid_o     = item_valid_q;
  assign out_id_o         = frame_q.id;
  assign out_ext_o        = frame_q.ext;
  assign out_rtr_o        = frame_q.rtr;
  assign out_len_o        = frame_q.len;
  assign out_payload_o    = frame_q.payload;
  assign out_time_o       = frame_q.stamp;
  assign occupancy_o      = ooff_pkg::OCC_W'(stats.count);
  assign high_water_o     = ooff_pkg::OCC_W'(stats.peak);
  assign put_total_o      = stats.put_total;
  assign get_total_o      = stats.get_total;
  assign overflow_total_o = stats.ovf_total;

endmodule

// File: rtl/ooff_checker.sv
`include "overwrite_oldest_frame_fifo_unit_macros.svh"

module ooff_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [ooff_pkg::MODE_W-1:0]   mode_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic                          item_valid_o,
  input  logic [ooff_pkg::ID_W-1:0]     out_id_o,
  input  logic [ooff_pkg::DATA_W-1:0]   out_payload_o,
  input  logic [ooff_pkg::TIME_W-1:0]   out_time_o,
  input  logic [ooff_pkg::OCC_W-1:0]    occupancy_o,
  input  logic [ooff_pkg::OCC_W-1:0]    high_water_o,
  input  logic [ooff_pkg::CTR_W-1:0]    put_total_o
);

  logic put_beat;
  logic empty_beat;
  logic frame_zero;

  assign put_beat   = in_valid_i && !in_stall_o && (mode_i == ooff_pkg::MODE_PUT);
  assign empty_beat = out_valid_o && !item_valid_o;
  assign frame_zero = (out_id_o == '0) && (out_payload_o == '0) && (out_time_o == '0);

  // a stalled result beat stays up
  `OOFF_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)

  // the high-water mark never lags the occupancy
  `OOFF_ASSERT_MSG(a_peak_ge_occ, high_water_o >= occupancy_o, "high-water below occupancy")

  // an empty result carries a zero frame
  `OOFF_ASSERT(a_empty_zero, empty_beat |-> frame_zero)

  // an accepted put bumps the put counter on the next cycle
  `OOFF_ASSERT(a_put_count, put_beat |=> put_total_o == $past(put_total_o) + 1'b1)

endmodule

bind overwrite_oldest_frame_fifo_unit ooff_checker u_ooff_checker (.*);
